// File: design/sum_tree_weighted_sampler_assert.svh
// Assertion macros used by the sum tree sampler top level.
`ifndef SUM_TREE_WEIGHTED_SAMPLER_ASSERT_SVH
`define SUM_TREE_WEIGHTED_SAMPLER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define STWS_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define STWS_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/stws_pkg.sv
// Types, codes and constants of the sum tree weighted sampler.
package stws_pkg;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  leaf_select;
        logic [31:0] new_weight;
        logic [31:0] random_fraction;
    } item_t;

    typedef struct packed {
        logic [9:0]  leaf_index;
        logic [31:0] leaf_weight;
        logic [41:0] total_weight;
        logic [1:0]  status;
    } result_t;

    // Operation codes; any other code is treated as a leaf read.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // Configuration port
    localparam int         APB_ADDR_BITS        = 2;
    localparam int         COUNT_BITS           = 11;
    localparam logic [1:0] ADDR_INSTANCE_COUNT  = 2'd0;
    localparam logic [10:0] INSTANCE_COUNT_RESET = 11'd1024;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_LOAD,
        DP_LEAF_RD,
        DP_LEAF_CAP,
        DP_UP_RD,
        DP_UP_ADD,
        DP_MUL_LO,
        DP_MUL_HI,
        DP_MUL_ADD,
        DP_DN_RD,
        DP_DN_STEP
    } dp_cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_LEAF_CAP,
        ST_UP_RD,
        ST_UP_ADD,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_ADD,
        ST_DESC,
        ST_DESC_STEP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic is_draw;
        logic is_read;
        logic skip;
        logic at_leaf;
        logic at_root;
        logic clr_last;
    } dp_sts_t;

endpackage

// File: design/sum_tree_weighted_sampler.sv
// Top level of the sum tree weighted sampler: config register, result register, units.
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+-------------------------
//  item     | in        | item_valid / item_ready     | stws_pkg::item_t
//  result   | out       | result_valid / result_ready | stws_pkg::result_t
//  config   | in        | psel/penable/pwrite, pready | paddr, pwdata, prdata
//
// A read fetches the leaf; a write then updates every level up to the root;
// a draw scales the total, descends to a leaf, empties it and updates the
// path; an error skips the tree. The block returns to idle before the next
// transaction is taken. The tree RAM has one read port, so each tree level
// takes a read state and a use state. After reset the RAM is cleared one
// node a cycle with item_ready low. A stalled result holds the finished item
// in the result register; the next item waits only for the one after that.
module sum_tree_weighted_sampler #(
    parameter int LEAF_COUNT  = 1024,
    parameter int WEIGHT_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  stws_pkg::item_t                      item,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output stws_pkg::result_t                    result,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [stws_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    `include "sum_tree_weighted_sampler_assert.svh"

    logic [stws_pkg::COUNT_BITS-1:0] instance_count_reg;
    logic [stws_pkg::COUNT_BITS-1:0] instance_count_next;
    logic                            result_valid_reg;
    logic                            result_valid_next;
    stws_pkg::result_t               result_reg;
    stws_pkg::result_t               result_next;

    stws_pkg::dp_cmd_t cmd;
    stws_pkg::dp_sts_t sts;
    stws_pkg::result_t dp_res;
    logic              out_load;
    logic              slot_free;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr == stws_pkg::ADDR_INSTANCE_COUNT);
    assign prdata = (paddr == stws_pkg::ADDR_INSTANCE_COUNT) ? 32'(instance_count_reg) : '0;
    assign instance_count_next = cfg_wr ? pwdata[stws_pkg::COUNT_BITS-1:0]
                                        : instance_count_reg;

    assign slot_free = !result_valid_reg || result_ready;

    stws_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .slot_free  (slot_free),
        .out_load   (out_load),
        .sts        (sts),
        .cmd        (cmd)
    );

    stws_dp #(
        .LEAF_COUNT  (LEAF_COUNT),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .item           (item),
        .instance_count (instance_count_reg),
        .sts            (sts),
        .res            (dp_res)
    );

    always_comb
    begin
        result_next       = out_load ? dp_res : result_reg;
        result_valid_next = result_valid_reg;
        priority if (out_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            instance_count_reg <= stws_pkg::INSTANCE_COUNT_RESET;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            instance_count_reg <= instance_count_next;
            result_valid_reg   <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `STWS_ASSERT_IMP(a_no_overwrite, out_load, !result_valid_reg || result_ready, "result overwritten before transaction")
    `STWS_ASSERT_NXT(a_one_in_flight, item_valid && item_ready, !item_ready, "second item taken while busy")
    `STWS_ASSERT_IMP(a_error_no_weight, result_valid && (result.status != stws_pkg::STATUS_OK), result.leaf_weight == 32'd0, "error result carries a weight")
    `STWS_ASSERT_IMP(a_empty_draw, result_valid && (result.status == stws_pkg::STATUS_EMPTY), (result.total_weight == 42'd0) && (result.leaf_index == 10'd0), "empty draw reports a leaf or total")

endmodule

// File: design/stws_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stws_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 2048,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/stws_ctrl.sv
// Control state machine of the sum tree sampler.
module stws_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic              slot_free,
    output logic              out_load,
    input  stws_pkg::dp_sts_t sts,
    output stws_pkg::dp_cmd_t cmd
);

    stws_pkg::state_t state_reg;
    stws_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stws_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = stws_pkg::DP_NOP;
        item_ready = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            stws_pkg::ST_CLEAR:
            begin
                cmd = stws_pkg::DP_CLEAR;
                if (sts.clr_last)
                begin
                    state_next = stws_pkg::ST_IDLE;
                end
            end
            stws_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd        = stws_pkg::DP_LOAD;
                    state_next = stws_pkg::ST_CHECK;
                end
            end
            stws_pkg::ST_CHECK:
            begin
                priority if (sts.skip)
                begin
                    state_next = stws_pkg::ST_FINISH;
                end
                else if (sts.is_draw)
                begin
                    state_next = stws_pkg::ST_MUL_LO;
                end
                else
                begin
                    cmd        = stws_pkg::DP_LEAF_RD;
                    state_next = stws_pkg::ST_LEAF_CAP;
                end
            end
            stws_pkg::ST_LEAF_CAP:
            begin
                cmd        = stws_pkg::DP_LEAF_CAP;
                state_next = sts.is_read ? stws_pkg::ST_FINISH : stws_pkg::ST_UP_RD;
            end
            stws_pkg::ST_UP_RD:
            begin
                cmd        = stws_pkg::DP_UP_RD;
                state_next = sts.at_root ? stws_pkg::ST_FINISH : stws_pkg::ST_UP_ADD;
            end
            stws_pkg::ST_UP_ADD:
            begin
                cmd        = stws_pkg::DP_UP_ADD;
                state_next = stws_pkg::ST_UP_RD;
            end
            stws_pkg::ST_MUL_LO:
            begin
                cmd        = stws_pkg::DP_MUL_LO;
                state_next = stws_pkg::ST_MUL_HI;
            end
            stws_pkg::ST_MUL_HI:
            begin
                cmd        = stws_pkg::DP_MUL_HI;
                state_next = stws_pkg::ST_MUL_ADD;
            end
            stws_pkg::ST_MUL_ADD:
            begin
                cmd        = stws_pkg::DP_MUL_ADD;
                state_next = stws_pkg::ST_DESC;
            end
            stws_pkg::ST_DESC:
            begin
                // read the leaf once reached, else the left child
                if (sts.at_leaf)
                begin
                    cmd        = stws_pkg::DP_LEAF_RD;
                    state_next = stws_pkg::ST_LEAF_CAP;
                end
                else
                begin
                    cmd        = stws_pkg::DP_DN_RD;
                    state_next = stws_pkg::ST_DESC_STEP;
                end
            end
            stws_pkg::ST_DESC_STEP:
            begin
                cmd        = stws_pkg::DP_DN_STEP;
                state_next = stws_pkg::ST_DESC;
            end
            stws_pkg::ST_FINISH:
            begin
                // hold until the result register is free
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    state_next = stws_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stws_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/stws_dp.sv
// Datapath of the sum tree sampler: tree RAM, path registers, scaling multiplier.
module stws_dp #(
    parameter int LEAF_COUNT  = 1024,
    parameter int WEIGHT_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  stws_pkg::dp_cmd_t                   cmd,
    input  stws_pkg::item_t                     item,
    input  logic [stws_pkg::COUNT_BITS-1:0]     instance_count,
    output stws_pkg::dp_sts_t                   sts,
    output stws_pkg::result_t                   res
);

    localparam int LEVELS    = $clog2(LEAF_COUNT);
    localparam int ADDR_BITS = LEVELS + 1;
    localparam int DEPTH     = 2 ** ADDR_BITS;
    localparam int SUM_RAW   = WEIGHT_BITS + LEVELS;
    localparam int SUM_BITS  = (SUM_RAW > 64) ? 64 : SUM_RAW;

    // control state
    logic [ADDR_BITS-1:0]   node_reg;
    logic [ADDR_BITS-1:0]   node_next;
    logic [SUM_BITS-1:0]    total_reg;
    logic [SUM_BITS-1:0]    total_next;

    // payload
    logic [1:0]             op_reg;
    logic [1:0]             op_next;
    logic [9:0]             sel_reg;
    logic [9:0]             sel_next;
    logic [WEIGHT_BITS-1:0] neww_reg;
    logic [WEIGHT_BITS-1:0] neww_next;
    logic [31:0]            frac_reg;
    logic [31:0]            frac_next;
    logic [SUM_BITS-1:0]    val_reg;
    logic [SUM_BITS-1:0]    val_next;
    logic [WEIGHT_BITS-1:0] oldw_reg;
    logic [WEIGHT_BITS-1:0] oldw_next;
    logic [LEVELS-1:0]      idx_reg;
    logic [LEVELS-1:0]      idx_next;
    logic [63:0]            prod_reg;
    logic [63:0]            prod_next;
    logic                   draw_empty_reg;
    logic                   draw_empty_next;

    logic                   ram_wr_en;
    logic [ADDR_BITS-1:0]   ram_rd_addr;
    logic [SUM_BITS-1:0]    ram_wr_data;
    logic [SUM_BITS-1:0]    ram_rd_data;

    logic [63:0]            total_ext;
    logic [31:0]            mul_b;
    logic [63:0]            mul_p;
    logic [31:0]            cnt_ext;
    logic [31:0]            cnt_lim;
    logic                   out_of_range;
    logic                   is_draw;
    logic                   is_read;
    logic                   empty;
    logic                   go_left;

    stws_ram #(
        .WIDTH (SUM_BITS),
        .DEPTH (DEPTH)
    ) u_tree (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (node_reg),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign is_draw = (op_reg == stws_pkg::OP_DRAW);
    // any code other than write or draw reads the leaf
    assign is_read = !(op_reg == stws_pkg::OP_WRITE) && !is_draw;
    assign empty   = (total_reg == '0);
    assign cnt_ext = 32'(instance_count);
    assign cnt_lim = (cnt_ext < 32'(LEAF_COUNT)) ? cnt_ext : 32'(LEAF_COUNT);
    assign out_of_range = (32'(sel_reg) >= cnt_lim);

    assign total_ext = 64'(total_reg);
    assign mul_b     = (cmd == stws_pkg::DP_MUL_HI) ? total_ext[63:32] : total_ext[31:0];
    assign mul_p     = 64'(frac_reg) * 64'(mul_b);
    assign go_left   = (ram_rd_data != '0) && (val_reg < ram_rd_data);

    assign sts.is_draw  = is_draw;
    assign sts.is_read  = is_read;
    assign sts.skip     = is_draw ? empty : out_of_range;
    assign sts.at_leaf  = node_reg[ADDR_BITS-1];
    assign sts.at_root  = (node_reg == ADDR_BITS'(1));
    assign sts.clr_last = &node_reg;

    assign ram_wr_en   = (cmd == stws_pkg::DP_CLEAR) || (cmd == stws_pkg::DP_UP_RD);
    assign ram_wr_data = (cmd == stws_pkg::DP_CLEAR) ? '0 : val_reg;

    always_comb
    begin
        unique case (cmd)
            stws_pkg::DP_UP_RD: ram_rd_addr = node_reg ^ ADDR_BITS'(1);
            stws_pkg::DP_DN_RD: ram_rd_addr = {node_reg[ADDR_BITS-2:0], 1'b0};
            default:            ram_rd_addr = node_reg;
        endcase
    end

    always_comb
    begin
        node_next       = node_reg;
        total_next      = total_reg;
        op_next         = op_reg;
        sel_next        = sel_reg;
        neww_next       = neww_reg;
        frac_next       = frac_reg;
        val_next        = val_reg;
        oldw_next       = oldw_reg;
        idx_next        = idx_reg;
        prod_next       = prod_reg;
        draw_empty_next = draw_empty_reg;
        unique case (cmd)
            stws_pkg::DP_CLEAR:
            begin
                node_next = node_reg + ADDR_BITS'(1);
            end
            stws_pkg::DP_LOAD:
            begin
                op_next   = item.op;
                sel_next  = item.leaf_select;
                neww_next = WEIGHT_BITS'(item.new_weight);
                frac_next = item.random_fraction;
                node_next = {1'b1, LEVELS'(32'(item.leaf_select))};
                // hold the emptiness seen on entry; a draw may empty the tree
                draw_empty_next = empty;
            end
            stws_pkg::DP_LEAF_CAP:
            begin
                oldw_next = WEIGHT_BITS'(ram_rd_data);
                idx_next  = node_reg[LEVELS-1:0];
                // a draw empties the leaf
                val_next  = (op_reg == stws_pkg::OP_WRITE) ? SUM_BITS'(neww_reg) : '0;
            end
            stws_pkg::DP_UP_RD:
            begin
                if (node_reg == ADDR_BITS'(1))
                begin
                    total_next = val_reg;
                end
            end
            stws_pkg::DP_UP_ADD:
            begin
                val_next  = val_reg + ram_rd_data;
                node_next = {1'b0, node_reg[ADDR_BITS-1:1]};
            end
            stws_pkg::DP_MUL_LO:
            begin
                prod_next = mul_p;
            end
            stws_pkg::DP_MUL_HI:
            begin
                val_next  = SUM_BITS'(prod_reg[63:32]);
                prod_next = mul_p;
            end
            stws_pkg::DP_MUL_ADD:
            begin
                val_next  = val_reg + SUM_BITS'(prod_reg);
                node_next = ADDR_BITS'(1);
            end
            stws_pkg::DP_DN_STEP:
            begin
                node_next = {node_reg[ADDR_BITS-2:0], ~go_left};
                if (!go_left)
                begin
                    val_next = val_reg - ram_rd_data;
                end
            end
            stws_pkg::DP_NOP, stws_pkg::DP_LEAF_RD, stws_pkg::DP_DN_RD:
            begin
                node_next = node_reg;
            end
            default:
            begin
                node_next = node_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_reg  <= '0;
            total_reg <= '0;
        end
        else
        begin
            node_reg  <= node_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        sel_reg        <= sel_next;
        neww_reg       <= neww_next;
        frac_reg       <= frac_next;
        val_reg        <= val_next;
        oldw_reg       <= oldw_next;
        idx_reg        <= idx_next;
        prod_reg       <= prod_next;
        draw_empty_reg <= draw_empty_next;
    end

    always_comb
    begin
        res.total_weight = 42'(total_reg);
        if (is_draw)
        begin
            res.leaf_index  = draw_empty_reg ? '0 : 10'(idx_reg);
            res.leaf_weight = draw_empty_reg ? '0 : 32'(oldw_reg);
            res.status      = draw_empty_reg ? stws_pkg::STATUS_EMPTY : stws_pkg::STATUS_OK;
        end
        else
        begin
            res.leaf_index  = sel_reg;
            res.leaf_weight = out_of_range ? '0 : 32'(oldw_reg);
            res.status      = out_of_range ? stws_pkg::STATUS_RANGE : stws_pkg::STATUS_OK;
        end
    end

endmodule
